[design/rtcd_pkg.sv]
package rtcd_pkg;

    localparam int unsigned MillisPerSec = 1000;
    localparam int unsigned YearBase     = 2000;

    typedef enum logic {
        FMT_SINGLE   = 1'b0,
        FMT_BUFFERED = 1'b1
    } rtcd_fmt_t;

    typedef struct packed {
        rtcd_fmt_t  op;
        logic [7:0] frac_high;
        logic [1:0] frac_low;
        logic [7:0] seconds_byte;
        logic [7:0] minutes_byte;
        logic [7:0] hours_byte;
        logic [7:0] day_byte;
        logic [7:0] month_byte;
        logic [7:0] year_byte;
        logic [7:0] status_byte;
    } rtcd_record_t;

    typedef struct packed {
        logic        valid_res;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
        logic        low_voltage;
        logic        voltage_compare;
        logic        voltage_detect;
        logic        osc_stop;
    } rtcd_result_t;

endpackage

[design/rtcd_decode.sv]
module rtcd_decode (
    input  rtcd_pkg::rtcd_record_t rec,
    output rtcd_pkg::rtcd_result_t res
);
    import rtcd_pkg::*;

    // digits both <= 9
    function automatic logic bcd_digits_ok(input logic [7:0] b);
        bcd_digits_ok = (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
    endfunction

    // only meaningful when the digits are valid
    function automatic logic [6:0] bcd_value(input logic [7:0] b);
        logic [6:0] tens;
        tens = {3'b000, b[7:4]} * 7'd10;
        bcd_value = tens + {3'b000, b[3:0]};
    endfunction

    logic [7:0]  sec_b, min_b, hr_b, day_b, mon_b, yr_b;
    logic [6:0]  sec_v, min_v, hr_v, day_v, mon_v, yr_v;
    logic        digits_ok;
    logic        range_ok;
    logic        ok;
    logic [9:0]  f10;
    logic [19:0] ms_single;
    logic [19:0] ms_buffered;
    logic [9:0]  ms;
    logic [11:0] year_full;

    assign sec_b = rec.seconds_byte & 8'h7F;
    assign min_b = rec.minutes_byte & 8'h7F;
    assign hr_b  = rec.hours_byte   & 8'h3F;
    assign day_b = rec.day_byte     & 8'h3F;
    assign mon_b = rec.month_byte   & 8'h1F;
    assign yr_b  = rec.year_byte;

    assign sec_v = bcd_value(sec_b);
    assign min_v = bcd_value(min_b);
    assign hr_v  = bcd_value(hr_b);
    assign day_v = bcd_value(day_b);
    assign mon_v = bcd_value(mon_b);
    assign yr_v  = bcd_value(yr_b);

    assign digits_ok = bcd_digits_ok(sec_b) && bcd_digits_ok(min_b) &&
                       bcd_digits_ok(hr_b)  && bcd_digits_ok(day_b) &&
                       bcd_digits_ok(mon_b) && bcd_digits_ok(yr_b);

    assign range_ok = (sec_v <= 7'd59) && (min_v <= 7'd59) && (hr_v <= 7'd23) &&
                      (day_v <= 7'd31) && (mon_v <= 7'd12) && (yr_v <= 7'd99) &&
                      (day_v != 7'd0) && (mon_v != 7'd0);

    assign ok = digits_ok && range_ok;

    // round to nearest ms: (f * 1000 + half) >> fraction bits
    assign f10         = {rec.frac_high, rec.frac_low};
    assign ms_single   = ({10'd0, f10} * 20'(MillisPerSec) + 20'd512) >> 10;
    assign ms_buffered = ({12'd0, rec.frac_high} * 20'(MillisPerSec) + 20'd128) >> 8;

    always_comb begin
        case (rec.op)
            FMT_SINGLE:   ms = ms_single[9:0];
            FMT_BUFFERED: ms = ms_buffered[9:0];
            default:      ms = ms_single[9:0];
        endcase
    end

    assign year_full = 12'(YearBase) + {5'd0, yr_v};

    always_comb begin
        res = '0;
        if (ok) begin
            res.valid_res       = 1'b1;
            res.year            = year_full;
            res.month           = mon_v[3:0];
            res.day             = day_v[4:0];
            res.hour            = hr_v[4:0];
            res.minute          = min_v[5:0];
            res.second          = sec_v[5:0];
            res.millis          = ms;
            res.low_voltage     = rec.status_byte[5];
            res.voltage_compare = rec.status_byte[4];
            res.voltage_detect  = rec.status_byte[3];
            res.osc_stop        = rec.status_byte[1];
        end
    end

endmodule

[design/rtc_timestamp_record_decoder.sv]
// RTC timestamp record decoder.
//
// Input channel (s_valid/s_ready): one raw timestamp record per request,
// either a single record (10-bit fraction in 1/1024 s) or a buffered one
// (8-bit fraction in 1/256 s), plus BCD time/date bytes and a status byte.
// Result channel (m_valid/m_ready): one decoded result per request:
// calendar fields with year 2000..2099, milliseconds rounded from the
// fraction, and four status flags. A record that fails a BCD digit or
// range check gives m_valid_res = 0 with every other field 0.
//
// The request lands in the input register at the accepting edge and passes
// the decode logic; the result register loads it when that register is empty
// or being drained. Throughput is one request
// per cycle; both registers advance whenever the stage ahead is empty or
// being drained, so s_ready stays high while the receiver takes results.
// When m_ready is low the result register holds, the input register fills,
// and s_ready drops after that; no request is lost or repeated.
// Reset (aresetn low at a clock edge) empties both stages.
module rtc_timestamp_record_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_frac_high,
    input  logic [1:0]  s_frac_low,
    input  logic [7:0]  s_seconds_byte,
    input  logic [7:0]  s_minutes_byte,
    input  logic [7:0]  s_hours_byte,
    input  logic [7:0]  s_day_byte,
    input  logic [7:0]  s_month_byte,
    input  logic [7:0]  s_year_byte,
    input  logic [7:0]  s_status_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [9:0]  m_millis,
    output logic        m_low_voltage,
    output logic        m_voltage_compare,
    output logic        m_voltage_detect,
    output logic        m_osc_stop
);
    import rtcd_pkg::*;

    logic         in_vld_reg;
    rtcd_record_t in_rec_reg;
    rtcd_record_t in_rec_next;
    logic         out_vld_reg;
    rtcd_result_t out_res_reg;
    rtcd_result_t dec_res;
    logic         out_load;
    logic         in_load;

    assign out_load = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || !out_vld_reg || m_ready;
    assign in_load  = s_valid && s_ready;

    assign in_rec_next = '{
        op:           rtcd_fmt_t'(s_op),
        frac_high:    s_frac_high,
        frac_low:     s_frac_low,
        seconds_byte: s_seconds_byte,
        minutes_byte: s_minutes_byte,
        hours_byte:   s_hours_byte,
        day_byte:     s_day_byte,
        month_byte:   s_month_byte,
        year_byte:    s_year_byte,
        status_byte:  s_status_byte
    };

    rtcd_decode u_decode (
        .rec (in_rec_reg),
        .res (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_vld_reg <= 1'b1;
            end else if (out_load) begin
                in_vld_reg <= 1'b0;
            end
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_rec_reg <= in_rec_next;
        end
        if (out_load) begin
            out_res_reg <= dec_res;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_valid_res       = out_res_reg.valid_res;
    assign m_year            = out_res_reg.year;
    assign m_month           = out_res_reg.month;
    assign m_day             = out_res_reg.day;
    assign m_hour            = out_res_reg.hour;
    assign m_minute          = out_res_reg.minute;
    assign m_second          = out_res_reg.second;
    assign m_millis          = out_res_reg.millis;
    assign m_low_voltage     = out_res_reg.low_voltage;
    assign m_voltage_compare = out_res_reg.voltage_compare;
    assign m_voltage_detect  = out_res_reg.voltage_detect;
    assign m_osc_stop        = out_res_reg.osc_stop;

    // failed check clears every field
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_year == 12'd0 && m_month == 4'd0 &&
        m_day == 5'd0 && m_hour == 5'd0 && m_minute == 6'd0 && m_second == 6'd0 &&
        m_millis == 10'd0 && !m_low_voltage && !m_voltage_compare &&
        !m_voltage_detect && !m_osc_stop))
        else $error("invalid result with nonzero fields");

    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> (m_year >= 12'd2000 && m_year <= 12'd2099 &&
        m_month != 4'd0 && m_month <= 4'd12 && m_day != 5'd0 && m_hour <= 5'd23 &&
        m_minute <= 6'd59 && m_second <= 6'd59 && m_millis <= 10'd999))
        else $error("decoded field out of range");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_vld_reg)
        else $error("accepted request not held in input stage");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_ready) |-> !s_ready)
        else $error("request accepted with both stages full");

endmodule

[tb/tb_top.sv]
module tb_top;
    import rtcd_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int RandomPerPhase = 176;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;

    logic        m_valid_res;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [9:0]  m_millis;
    logic        m_low_voltage;
    logic        m_voltage_compare;
    logic        m_voltage_detect;
    logic        m_osc_stop;

    rtcd_record_t pending_records[$];
    rtcd_result_t expected_decodes[$];
    rtcd_record_t drive_rec = '0;
    rtcd_result_t result_seen;
    rtcd_result_t want;

    logic req_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   error_count = 0;
    int   records_sent = 0;
    int   results_checked = 0;
    int   valid_decodes = 0;
    int   idle_cycles = 0;

    rtc_timestamp_record_decoder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (drive_rec.op),
        .s_frac_high       (drive_rec.frac_high),
        .s_frac_low        (drive_rec.frac_low),
        .s_seconds_byte    (drive_rec.seconds_byte),
        .s_minutes_byte    (drive_rec.minutes_byte),
        .s_hours_byte      (drive_rec.hours_byte),
        .s_day_byte        (drive_rec.day_byte),
        .s_month_byte      (drive_rec.month_byte),
        .s_year_byte       (drive_rec.year_byte),
        .s_status_byte     (drive_rec.status_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_year            (m_year),
        .m_month           (m_month),
        .m_day             (m_day),
        .m_hour            (m_hour),
        .m_minute          (m_minute),
        .m_second          (m_second),
        .m_millis          (m_millis),
        .m_low_voltage     (m_low_voltage),
        .m_voltage_compare (m_voltage_compare),
        .m_voltage_detect  (m_voltage_detect),
        .m_osc_stop        (m_osc_stop)
    );

    assign result_seen = {m_valid_res, m_year, m_month, m_day, m_hour, m_minute, m_second,
                          m_millis, m_low_voltage, m_voltage_compare, m_voltage_detect,
                          m_osc_stop};

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic bit bcd_value(input logic [7:0] b, input int unsigned lim,
                                     output int unsigned v);
        v = b[7:4] * 10 + b[3:0];
        return (b[3:0] <= 9) && (b[7:4] <= 9) && (v <= lim);
    endfunction

    function automatic rtcd_result_t decode_timestamp(input rtcd_record_t r);
        rtcd_result_t res;
        int unsigned  ms, sec, mnt, hr, dy, mon, yr;
        bit           ok;
        res = '0;
        if (r.op == FMT_SINGLE)
            ms = ({r.frac_high, r.frac_low} * 1000 + 512) / 1024;
        else
            ms = (r.frac_high * 1000 + 128) / 256;
        ok = bcd_value(r.seconds_byte & 8'h7F, 59, sec)
           & bcd_value(r.minutes_byte & 8'h7F, 59, mnt)
           & bcd_value(r.hours_byte & 8'h3F, 23, hr)
           & bcd_value(r.day_byte & 8'h3F, 31, dy)
           & bcd_value(r.month_byte & 8'h1F, 12, mon)
           & bcd_value(r.year_byte, 99, yr);
        if (ok && dy != 0 && mon != 0) begin
            res.valid_res       = 1'b1;
            res.year            = 12'(YearBase + yr);
            res.month           = 4'(mon);
            res.day             = 5'(dy);
            res.hour            = 5'(hr);
            res.minute          = 6'(mnt);
            res.second          = 6'(sec);
            res.millis          = 10'(ms);
            res.low_voltage     = r.status_byte[5];
            res.voltage_compare = r.status_byte[4];
            res.voltage_detect  = r.status_byte[3];
            res.osc_stop        = r.status_byte[1];
        end
        return res;
    endfunction

    function automatic rtcd_record_t make_record(input rtcd_fmt_t op, input logic [7:0] fh,
                                                 input logic [1:0] fl, input logic [7:0] sec,
                                                 input logic [7:0] mnt, input logic [7:0] hr,
                                                 input logic [7:0] dy, input logic [7:0] mon,
                                                 input logic [7:0] yr, input logic [7:0] st);
        rtcd_record_t r;
        r.op           = op;
        r.frac_high    = fh;
        r.frac_low     = fl;
        r.seconds_byte = sec;
        r.minutes_byte = mnt;
        r.hours_byte   = hr;
        r.day_byte     = dy;
        r.month_byte   = mon;
        r.year_byte    = yr;
        r.status_byte  = st;
        return r;
    endfunction

    // mostly well-formed timestamps with junk in the ignored bits, some broken, some noise
    function automatic rtcd_record_t random_record();
        rtcd_record_t r;
        int           kind, fld;
        kind = $urandom_range(99);
        fld  = $urandom_range(5);
        r.op           = rtcd_fmt_t'($urandom_range(1));
        r.frac_high    = 8'($urandom);
        r.frac_low     = 2'($urandom);
        r.seconds_byte = to_bcd($urandom_range(59)) | (8'($urandom) & 8'h80);
        r.minutes_byte = to_bcd($urandom_range(59)) | (8'($urandom) & 8'h80);
        r.hours_byte   = to_bcd($urandom_range(23)) | (8'($urandom) & 8'hC0);
        r.day_byte     = to_bcd($urandom_range(1, 31)) | (8'($urandom) & 8'hC0);
        r.month_byte   = to_bcd($urandom_range(1, 12)) | (8'($urandom) & 8'hE0);
        r.year_byte    = to_bcd($urandom_range(99));
        r.status_byte  = 8'($urandom);
        if (kind < 10) begin
            r = rtcd_record_t'({$urandom, $urandom, $urandom});
        end else if (kind < 18) begin
            case (fld)
                0: r.seconds_byte[3:0] = 4'($urandom_range(10, 15));
                1: r.minutes_byte[3:0] = 4'($urandom_range(10, 15));
                2: r.hours_byte[3:0]   = 4'($urandom_range(10, 15));
                3: r.day_byte[3:0]     = 4'($urandom_range(10, 15));
                4: r.month_byte[3:0]   = 4'($urandom_range(10, 15));
                default: r.year_byte[3:0] = 4'($urandom_range(10, 15));
            endcase
        end else if (kind < 26) begin
            case (fld)
                0: r.seconds_byte[6:0] = 7'(to_bcd($urandom_range(60, 79)));
                1: r.minutes_byte[6:0] = 7'(to_bcd($urandom_range(60, 79)));
                2: r.hours_byte[5:0]   = 6'(to_bcd($urandom_range(24, 39)));
                3: r.day_byte[5:0]     = $urandom_range(1) ? 6'(to_bcd($urandom_range(32, 39)))
                                                           : 6'h0;
                4: r.month_byte[4:0]   = $urandom_range(1) ? 5'(to_bcd($urandom_range(13, 19)))
                                                           : 5'h0;
                default: r.year_byte[7:4] = 4'($urandom_range(10, 15));
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    // request driver
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_records.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_rec <= pending_records.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // acceptance tracking, result checking, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_decodes.push_back(decode_timestamp(drive_rec));
                records_sent++;
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_decodes.size() == 0) begin
                    $display("%0t: result with nothing pending: %h", $time, result_seen);
                    error_count++;
                end else begin
                    want = expected_decodes.pop_front();
                    valid_decodes += want.valid_res;
                    check_field("valid_res", want.valid_res, result_seen.valid_res);
                    check_field("year", want.year, result_seen.year);
                    check_field("month", want.month, result_seen.month);
                    check_field("day", want.day, result_seen.day);
                    check_field("hour", want.hour, result_seen.hour);
                    check_field("minute", want.minute, result_seen.minute);
                    check_field("second", want.second, result_seen.second);
                    check_field("millis", want.millis, result_seen.millis);
                    check_field("low_voltage", want.low_voltage, result_seen.low_voltage);
                    check_field("voltage_compare", want.voltage_compare,
                                result_seen.voltage_compare);
                    check_field("voltage_detect", want.voltage_detect,
                                result_seen.voltage_detect);
                    check_field("osc_stop", want.osc_stop, result_seen.osc_stop);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: watchdog, no progress in %0d cycles", $time, idle_cycles);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        // edge cases first
        pending_records.push_back(make_record(FMT_SINGLE, 8'h00, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h00, 8'h00, 8'h00, 8'h00));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'hFF, 2'h3, 8'hFF, 8'hFF, 8'hFF,
                                              8'hFF, 8'hFF, 8'hFF, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h00, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'h00, 8'h00));
        pending_records.push_back(make_record(FMT_SINGLE, 8'hFF, 2'h3, 8'h59, 8'h59, 8'h23,
                                              8'h31, 8'h12, 8'h99, 8'hFF));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'hFF, 2'h3, 8'hD9, 8'hD9, 8'hE3,
                                              8'hF1, 8'hF2, 8'h99, 8'h3A));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h00, 2'h3, 8'h30, 8'h15, 8'h12,
                                              8'h15, 8'h06, 8'h50, 8'h00));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h00, 2'h1, 8'h01, 8'h02, 8'h03,
                                              8'h04, 8'h05, 8'h06, 8'h20));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h80, 2'h2, 8'h45, 8'h30, 8'h19,
                                              8'h28, 8'h02, 8'h24, 8'h10));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h80, 2'h0, 8'h10, 8'h20, 8'h08,
                                              8'h09, 8'h10, 8'h11, 8'h08));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h01, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'h00, 8'h02));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h0A, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h60, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h00, 8'h5A, 8'h00,
                                              8'h01, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h00, 8'h00, 8'h24,
                                              8'h01, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h40, 2'h0, 8'h00, 8'h00, 8'h2A,
                                              8'h01, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h32, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h00, 8'h01, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h13, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h00, 8'h00, 8'hFF));
        pending_records.push_back(make_record(FMT_SINGLE, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'hA0, 8'hFF));
        pending_records.push_back(make_record(FMT_BUFFERED, 8'h40, 2'h0, 8'h00, 8'h00, 8'h00,
                                              8'h01, 8'h01, 8'h9A, 8'hFF));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 55 : 0;
            recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 10 : 0;
            for (int i = 0; i < RandomPerPhase; i++)
                pending_records.push_back(random_record());
            wait (pending_records.size() == 0 && !s_valid);
        end

        wait (expected_decodes.size() == 0);
        repeat (8) @(posedge aclk);

        $display("tb_top: %0d records sent, %0d results checked, %0d decoded as valid",
                 records_sent, results_checked, valid_decodes);
        $display("tb_top: both formats under sender-heavy, receiver-heavy and free-flow traffic");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
